### design/rsde_pkg.sv
package rsde_pkg;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [11:0] pos_x;
		logic signed [11:0] pos_y;
		logic signed [11:0] size_w;
		logic signed [11:0] size_h;
		logic [9:0]         radius;
		logic [31:0]        color_word;
		logic [7:0]         alpha;
	} cmd_t;

	typedef struct packed {
		logic [31:0] read_value;
		logic        in_clip;
	} rsp_t;

	localparam logic [2:0] ACT_CLEAR = 3'd0;
	localparam logic [2:0] ACT_PIXEL = 3'd1;
	localparam logic [2:0] ACT_RING  = 3'd2;
	localparam logic [2:0] ACT_DISC  = 3'd3;
	localparam logic [2:0] ACT_OUTL  = 3'd4;
	localparam logic [2:0] ACT_FILL  = 3'd5;
	localparam logic [2:0] ACT_ROUND = 3'd6;
	localparam logic [2:0] ACT_READ  = 3'd7;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_PITCH  = 2'd2;

	// shape kinds walked by the scanner
	localparam logic [1:0] SHP_BOX  = 2'd0; // blended filled box (pixel, edges)
	localparam logic [1:0] SHP_RECT = 2'd1; // unblended filled box
	localparam logic [1:0] SHP_DISC = 2'd2;
	localparam logic [1:0] SHP_RING = 2'd3;

	// per-channel blend: (f*a + b*(255-a)) / 255
	function automatic logic [7:0] blend_ch(input logic [7:0] f, input logic [7:0] b,
			input logic [7:0] a);
		logic [16:0] s;
		logic [25:0] p;
		s = 17'(f * a) + 17'(b * (8'd255 - a));
		// exact /255 for s < 65536: (s*257 + 257) >> 16
		p = 26'(s) * 26'd257 + 26'd257;
		return p[23:16];
	endfunction

	function automatic logic [31:0] blend_px(input logic [31:0] fg, input logic [31:0] bg,
			input logic [7:0] a);
		if (a == 8'd0) return bg;
		return {8'd0, blend_ch(fg[23:16], bg[23:16], a), blend_ch(fg[15:8], bg[15:8], a),
			blend_ch(fg[7:0], bg[7:0], a)};
	endfunction

endpackage

### design/raster_shape_draw_engine.sv
// Clear writes the color word to the first min(w*h,FB_WORDS) words. A read passes the
// read and write-back states only inside the clip and the store. A shape has a setup
// state per part and, per pixel of its clipped bounding box, a scan, a read and a
// write-back when drawn, only a scan when skipped, then a done state. Rounded rectangles
// walk six parts. A new command is taken only in idle, once the last is through; the
// result beat is registered and the next command is taken while it waits. Reset clears
// control state, sets the size registers to 256 and leaves the frame store as it is.
module raster_shape_draw_engine #(
	parameter int FB_WORDS = 65536,
	parameter int MAX_DIM  = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rsde_pkg::cmd_t    in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output rsde_pkg::rsp_t    out_data,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [8:0]        cfg_data
);
	localparam int AW = $clog2(FB_WORDS);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SETUP = 7'b0000010,
		ST_SCAN  = 7'b0000100,
		ST_RD    = 7'b0001000,
		ST_WB    = 7'b0010000,
		ST_CLEAR = 7'b0100000,
		ST_DONE  = 7'b1000000
	} st_t;

	st_t            st_q;
	rsde_pkg::cmd_t cmd_q;
	logic [8:0]     wid_q, hgt_q, pitch_q;
	logic [2:0]     part_q;
	logic [1:0]     kind_q;
	logic signed [13:0] x0_q, x1_q, y1_q, cx_q, cy_q, px_q, py_q;
	logic [21:0]    r2_q, r2o_q;
	logic [20:0]    clr_n_q, clr_i_q;
	logic [AW-1:0]  addr_q;
	logic           rdflag_q;
	logic [31:0]    rdval_q;
	logic [31:0]    mem_rd_q;
	logic           out_valid_q;
	rsde_pkg::rsp_t out_q;
	logic [31:0]    frame_mem [FB_WORDS];

	// clip sizes
	logic [10:0] cw, ch;
	assign cw = (11'(wid_q) < 11'(MAX_DIM)) ? 11'(wid_q) : 11'(MAX_DIM);
	assign ch = (11'(hgt_q) < 11'(MAX_DIM)) ? 11'(hgt_q) : 11'(MAX_DIM);

	// shape geometry for the current part
	logic signed [13:0] sx, sy, sw, sh, r14, gx, gy;
	logic [1:0]         skind;
	always_comb begin
		r14   = 14'(cmd_q.radius);
		gx    = 14'(cmd_q.pos_x);
		gy    = 14'(cmd_q.pos_y);
		sx    = gx; sy = gy; sw = 14'(cmd_q.size_w); sh = 14'(cmd_q.size_h);
		skind = rsde_pkg::SHP_BOX;
		unique case (cmd_q.action)
			rsde_pkg::ACT_PIXEL: begin sw = 14'sd1; sh = 14'sd1; end
			rsde_pkg::ACT_RING:  skind = rsde_pkg::SHP_RING;
			rsde_pkg::ACT_DISC:  skind = rsde_pkg::SHP_DISC;
			rsde_pkg::ACT_FILL:  skind = rsde_pkg::SHP_RECT;
			rsde_pkg::ACT_OUTL: begin
				case (part_q)
					3'd0: sh = 14'sd1;
					3'd1: begin sy = gy + sh - 14'sd1; sh = 14'sd1; end
					3'd2: sw = 14'sd1;
					default: begin sx = gx + sw - 14'sd1; sw = 14'sd1; end
				endcase
			end
			rsde_pkg::ACT_ROUND: begin
				case (part_q)
					3'd0: begin skind = rsde_pkg::SHP_RECT; sx = gx + r14;
						sw = sw - (r14 <<< 1); end
					3'd1: begin skind = rsde_pkg::SHP_RECT; sy = gy + r14;
						sh = sh - (r14 <<< 1); end
					3'd2: begin skind = rsde_pkg::SHP_DISC; sx = gx + r14; sy = gy + r14; end
					3'd3: begin skind = rsde_pkg::SHP_DISC; sx = gx + sw - r14;
						sy = gy + r14; end
					3'd4: begin skind = rsde_pkg::SHP_DISC; sx = gx + r14;
						sy = gy + sh - r14; end
					default: begin skind = rsde_pkg::SHP_DISC; sx = gx + sw - r14;
						sy = gy + sh - r14; end
				endcase
			end
			default: ;
		endcase
	end

	// bounding box of the part, clipped
	logic signed [13:0] bx0, bx1, by0, by1, e;
	always_comb begin
		e = (skind == rsde_pkg::SHP_RING) ? r14 + 14'sd1 : r14;
		if (skind == rsde_pkg::SHP_DISC || skind == rsde_pkg::SHP_RING) begin
			bx0 = sx - e; bx1 = sx + e; by0 = sy - e; by1 = sy + e;
		end else begin
			bx0 = sx; bx1 = sx + sw - 14'sd1; by0 = sy; by1 = sy + sh - 14'sd1;
			if (sw <= 0 || sh <= 0) begin bx1 = -14'sd1; by1 = -14'sd1; end
		end
		if (bx0 < 0) bx0 = '0;
		if (by0 < 0) by0 = '0;
		if (bx1 > $signed(14'(cw)) - 14'sd1) bx1 = $signed(14'(cw)) - 14'sd1;
		if (by1 > $signed(14'(ch)) - 14'sd1) by1 = $signed(14'(ch)) - 14'sd1;
	end

	logic [2:0] last_part;
	always_comb begin
		case (cmd_q.action)
			rsde_pkg::ACT_OUTL:  last_part = 3'd3;
			rsde_pkg::ACT_ROUND: last_part = 3'd5;
			default:             last_part = 3'd0;
		endcase
	end

	// squared-distance test on the current pixel
	logic signed [13:0] dx, dy;
	logic [21:0] dd;
	logic        hit;
	logic [31:0] off;
	always_comb begin
		dx  = px_q - cx_q;
		dy  = py_q - cy_q;
		dd  = 22'(dx * dx) + 22'(dy * dy);
		case (kind_q)
			rsde_pkg::SHP_DISC: hit = dd <= r2_q;
			rsde_pkg::SHP_RING: hit = dd >= r2_q && dd <= r2o_q;
			default:            hit = 1'b1;
		endcase
		off = 32'(py_q[8:0]) * 32'(pitch_q) + 32'(px_q[8:0]);
	end

	logic row_end, box_end;
	assign row_end = px_q >= x1_q;
	assign box_end = row_end && py_q >= y1_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wid_q <= 9'd256; hgt_q <= 9'd256; pitch_q <= 9'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rsde_pkg::REG_WIDTH:  wid_q   <= cfg_data;
				rsde_pkg::REG_HEIGHT: hgt_q   <= cfg_data;
				rsde_pkg::REG_PITCH:  pitch_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready  = (st_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; out_valid_q <= 1'b0; part_q <= '0;
		end else begin
			if (out_valid_q && out_ready && st_q != ST_DONE) out_valid_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (in_valid && in_ready) begin
					cmd_q <= in_data; part_q <= '0; rdflag_q <= 1'b0; rdval_q <= '0;
					st_q <= (in_data.action == rsde_pkg::ACT_CLEAR) ? ST_CLEAR : ST_SETUP;
					clr_i_q <= '0;
					clr_n_q <= 21'(cw * ch) > 21'(FB_WORDS) ? 21'(FB_WORDS) : 21'(cw * ch);
				end
				ST_CLEAR: begin
					if (clr_i_q >= clr_n_q) st_q <= ST_DONE;
					else clr_i_q <= clr_i_q + 21'd1;
				end
				ST_SETUP: begin
					if (cmd_q.action == rsde_pkg::ACT_READ) begin
						if (gx >= 0 && gx < $signed(14'(cw)) && gy >= 0 &&
								gy < $signed(14'(ch)))
							rdflag_q <= 1'b1;
						px_q <= gx; py_q <= gy;
						st_q <= ST_SCAN;
					end else begin
						kind_q <= skind; cx_q <= sx; cy_q <= sy;
						r2_q  <= 22'(r14 * r14);
						r2o_q <= 22'((r14 + 14'sd1) * (r14 + 14'sd1));
						x0_q <= bx0; x1_q <= bx1; y1_q <= by1;
						px_q <= bx0; py_q <= by0;
						if (bx0 > bx1 || by0 > by1) begin
							if (part_q == last_part) st_q <= ST_DONE;
							else part_q <= part_q + 3'd1;
						end else st_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					addr_q <= off[AW-1:0];
					if (cmd_q.action == rsde_pkg::ACT_READ) begin
						if (rdflag_q && off < 32'(FB_WORDS)) st_q <= ST_RD;
						else st_q <= ST_DONE;
					end else if (hit && off < 32'(FB_WORDS)) st_q <= ST_RD;
					else if (box_end) begin
						if (part_q == last_part) st_q <= ST_DONE;
						else begin part_q <= part_q + 3'd1; st_q <= ST_SETUP; end
					end else if (row_end) begin px_q <= x0_q; py_q <= py_q + 14'sd1; end
					else px_q <= px_q + 14'sd1;
				end
				ST_RD: st_q <= ST_WB;
				ST_WB: begin
					if (cmd_q.action == rsde_pkg::ACT_READ) begin
						rdval_q <= mem_rd_q;
						st_q <= ST_DONE;
					end else if (box_end) begin
						if (part_q == last_part) st_q <= ST_DONE;
						else begin part_q <= part_q + 3'd1; st_q <= ST_SETUP; end
					end else begin
						st_q <= ST_SCAN;
						if (row_end) begin px_q <= x0_q; py_q <= py_q + 14'sd1; end
						else px_q <= px_q + 14'sd1;
					end
				end
				// hold until the previous result beat has left
				ST_DONE: if (!out_valid_q || out_ready) begin
					if (cmd_q.action == rsde_pkg::ACT_READ) out_q <= {rdval_q, rdflag_q};
					else out_q <= '0;
					out_valid_q <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// frame store: one read and one write per cycle
	logic        wr_en;
	logic [31:0] wr_data;
	always_comb begin
		wr_en   = (st_q == ST_WB && cmd_q.action != rsde_pkg::ACT_READ) ||
			(st_q == ST_CLEAR && clr_i_q < clr_n_q);
		wr_data = cmd_q.color_word;
		if (st_q == ST_WB && kind_q != rsde_pkg::SHP_RECT && cmd_q.alpha != 8'd255)
			wr_data = rsde_pkg::blend_px(cmd_q.color_word, mem_rd_q, cmd_q.alpha);
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			frame_mem[(st_q == ST_CLEAR) ? clr_i_q[AW-1:0] : addr_q] <= wr_data;
		mem_rd_q <= frame_mem[addr_q];
	end
endmodule
